// File: rtl/dotted_path_hash_unit_defines.svh
// ----------------------------------------------------------------------------
// Dotted path hash unit: assertion macros
// Shared property wrappers; they rely on clock and reset in the enclosing scope.
// ----------------------------------------------------------------------------
`ifndef DOTTED_PATH_HASH_UNIT_DEFINES_SVH
`define DOTTED_PATH_HASH_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define DPH_ASSERT_IMP(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define DPH_ASSERT_NXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication that also holds across reset
`define DPH_ASSERT_RST(name, ante, cons, msg) \
   name: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/dph_pkg.sv
// ----------------------------------------------------------------------------
// Dotted path hash package
// Payload types, command and status structs, and hash constants.
// ----------------------------------------------------------------------------
package dph_pkg;

   localparam logic [63:0] HASH_SEED   = 64'hEE67_4237;
   localparam logic [63:0] LOW_NIBBLES = 64'h0F0F_0F0F_0F0F_0F0F;
   // accumulation of "$$arr"
   localparam logic [63:0] ARR_PRESET  =
      (((64'd36 * 64'd257 + 64'd36) * 64'd257 + 64'd97) * 64'd257 + 64'd114) * 64'd257
      + 64'd114;

   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_OPEN  = 8'h5B;
   localparam logic [7:0] CHAR_CLOSE = 8'h5D;

   typedef struct packed {
      logic [7:0] char_byte;
      logic       has_byte;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [63:0] id_hash;
      logic        utf8_error;
   } rsp_type;

   // partial-product phase of the shared 32x32 multiplier
   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_LL,
      MUL_LH,
      MUL_HL,
      MUL_DONE
   } mul_phase_type;

   typedef struct packed {
      logic          take_item;
      logic          prep_factor;
      mul_phase_type mul_phase;
      logic          load_out;
   } cmd_type;

   typedef struct packed {
      logic fold_byte;
      logic last_item;
   } status_type;

endpackage

// File: rtl/dph_ctrl.sv
// ----------------------------------------------------------------------------
// Dotted path hash controller
// Sequences item intake, component folds and result hand-off.
// ----------------------------------------------------------------------------
module dph_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  dph_pkg::status_type status,
   output dph_pkg::cmd_type    cmd
);
   import dph_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_MUL0,
      ST_MUL1,
      ST_MUL2,
      ST_MUL3,
      ST_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      last_ff, last_in;
   logic      final_fold_ff, final_fold_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      take;
   logic      slot_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign take      = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in      = state_ff;
      last_in       = last_ff;
      final_fold_in = final_fold_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      cmd           = '{take_item: take, prep_factor: 1'b0,
                        mul_phase: MUL_NONE, load_out: 1'b0};
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               last_in       = status.last_item;
               final_fold_in = 1'b0;
               if (status.fold_byte) begin
                  state_in = ST_MUL0;
               end else if (status.last_item) begin
                  state_in = ST_PREP;
               end
            end
         end
         ST_PREP: begin
            cmd.prep_factor = 1'b1;
            final_fold_in   = 1'b1;
            state_in        = ST_MUL0;
         end
         ST_MUL0: begin
            cmd.mul_phase = MUL_LL;
            state_in      = ST_MUL1;
         end
         ST_MUL1: begin
            cmd.mul_phase = MUL_LH;
            state_in      = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul_phase = MUL_HL;
            state_in      = ST_MUL3;
         end
         ST_MUL3: begin
            cmd.mul_phase = MUL_DONE;
            if (final_fold_ff) begin
               state_in = ST_OUT;
            end else if (last_ff) begin
               state_in = ST_PREP;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT: begin
            if (slot_free) begin
               cmd.load_out  = 1'b1;
               rsp_valid_in  = 1'b1;
               last_in       = 1'b0;
               final_fold_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         last_ff       <= 1'b0;
         final_fold_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         last_ff       <= last_in;
         final_fold_ff <= final_fold_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

endmodule

// File: rtl/dph_datapath.sv
// ----------------------------------------------------------------------------
// Dotted path hash datapath
// UTF-8 tracking, component accumulator, split 64-bit multiply and output stage.
// ----------------------------------------------------------------------------
module dph_datapath (
   input  logic                clock,
   input  logic                reset,
   input  dph_pkg::req_type    req_data,
   output dph_pkg::rsp_type    rsp_data,
   input  dph_pkg::cmd_type    cmd,
   output dph_pkg::status_type status
);
   import dph_pkg::*;

   logic [63:0] hash_ff, hash_in;
   logic [63:0] acc_ff, acc_in;
   logic [1:0]  pend_ff, pend_in;
   logic        bad_ff, bad_in;
   logic [63:0] factor_ff;
   logic [63:0] mul_ff;
   logic [63:0] prod_ff;
   rsp_type     rsp_ff;

   logic [7:0]  b;
   logic        is_fold;
   logic [63:0] factor_calc;
   logic [31:0] op_a, op_b;
   logic [63:0] mul_out;
   logic [63:0] full_prod;
   logic [63:0] swapped;
   logic        err;

   assign b       = req_data.char_byte;
   assign is_fold = req_data.has_byte && (b == CHAR_DOT || b == CHAR_OPEN);
   assign status  = '{fold_byte: is_fold, last_item: req_data.last};

   // acc*37 + 2 as shifts and adds
   assign factor_calc = (acc_ff << 5) + (acc_ff << 2) + acc_ff + 64'd2;

   // one shared 32x32 multiplier; low 64 bits of hash*factor over three products
   assign op_a    = (cmd.mul_phase == MUL_HL) ? hash_ff[63:32] : hash_ff[31:0];
   assign op_b    = (cmd.mul_phase == MUL_LH) ? factor_ff[63:32] : factor_ff[31:0];
   assign mul_out = 64'(op_a) * 64'(op_b);

   assign full_prod = {prod_ff[63:32] + mul_ff[31:0], prod_ff[31:0]};
   assign swapped   = ((full_prod & LOW_NIBBLES) << 4) | ((full_prod >> 4) & LOW_NIBBLES);

   assign err = bad_ff || (pend_ff != 2'd0);

   always_comb begin
      hash_in = hash_ff;
      acc_in  = acc_ff;
      pend_in = pend_ff;
      bad_in  = bad_ff;
      if (cmd.take_item && req_data.has_byte) begin
         if (pend_ff == 2'd0) begin
            priority if (b[7] == 1'b0) begin
               pend_in = 2'd0;
            end else if (b[7:5] == 3'b110) begin
               pend_in = 2'd1;
            end else if (b[7:4] == 4'b1110) begin
               pend_in = 2'd2;
            end else if (b[7:3] == 5'b11110) begin
               pend_in = 2'd3;
            end else begin
               bad_in = 1'b1;
            end
         end else if (b[7:6] == 2'b10) begin
            pend_in = pend_ff - 2'd1;
         end else begin
            bad_in = 1'b1;
         end
         if (b == CHAR_DOT) begin
            acc_in = '0;
         end else if (b == CHAR_OPEN) begin
            acc_in = ARR_PRESET;
         end else if (b != CHAR_CLOSE) begin
            acc_in = (acc_ff << 8) + acc_ff + 64'(b);
         end
      end
      if (cmd.mul_phase == MUL_DONE) begin
         hash_in = {swapped[55:0], swapped[63:56]};
      end
      if (cmd.load_out) begin
         hash_in = HASH_SEED;
         acc_in  = '0;
         pend_in = 2'd0;
         bad_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= HASH_SEED;
         acc_ff  <= '0;
         pend_ff <= 2'd0;
         bad_ff  <= 1'b0;
      end else begin
         hash_ff <= hash_in;
         acc_ff  <= acc_in;
         pend_ff <= pend_in;
         bad_ff  <= bad_in;
      end
   end

   always_ff @(posedge clock) begin
      if ((cmd.take_item && is_fold) || cmd.prep_factor) begin
         factor_ff <= factor_calc;
      end
      if (cmd.mul_phase != MUL_NONE) begin
         mul_ff <= mul_out;
      end
      if (cmd.mul_phase == MUL_LH) begin
         prod_ff <= mul_ff;
      end else if (cmd.mul_phase == MUL_HL) begin
         prod_ff[63:32] <= prod_ff[63:32] + mul_ff[31:0];
      end
      if (cmd.load_out) begin
         rsp_ff.id_hash    <= err ? 64'd0 : hash_ff;
         rsp_ff.utf8_error <= err;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// File: rtl/dotted_path_hash_unit.sv
// Plain byte: one transfer per cycle while intake is open. Separator ('.' or '['):
// intake closes while the fold runs through one shared 32x32 multiplier as three
// partial products plus a write-back. Final item: the result passes a final fold and
// the output load, after the byte fold for a final separator; intake reopens as the result
// is loaded, which waits only while an earlier result still sits in the output register.
// Synchronous active-high reset returns the hash to its seed and empties the output.
// ----------------------------------------------------------------------------
// Dotted path hash unit
// Streaming hash of a dotted path with UTF-8 validity check.
// ----------------------------------------------------------------------------
module dotted_path_hash_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  dph_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dph_pkg::rsp_type rsp_data
);
   import dph_pkg::*;

   cmd_type    cmd;
   status_type status;

   dph_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   dph_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .rsp_data (rsp_data),
      .cmd      (cmd),
      .status   (status)
   );

endmodule

// File: rtl/dph_checker.sv
// ----------------------------------------------------------------------------
// Dotted path hash checker
// Port-level properties of the hash unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "dotted_path_hash_unit_defines.svh"

module dph_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input dph_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input dph_pkg::rsp_type rsp_data
);
   import dph_pkg::*;

   `DPH_ASSERT_RST(a_reset_empty, reset, !rsp_valid, "result valid after reset")
   `DPH_ASSERT_IMP(a_err_zero, rsp_valid && rsp_data.utf8_error, rsp_data.id_hash == 64'd0, "hash not zero on error")
   `DPH_ASSERT_NXT(a_mid_no_rsp, req_valid && req_ready && !req_data.last, !$rose(rsp_valid), "result after non-final transfer")
   `DPH_ASSERT_NXT(a_final_busy, req_valid && req_ready && req_data.last, !req_ready, "intake open during final fold")
   `DPH_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled result changed")

endmodule

bind dotted_path_hash_unit dph_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
